// File: design/pcts_pkg.sv
// ----------------------------------------------------------------------------
// pcts_pkg
// Shared types, constants and helper functions for the priority counter
// task scheduler: cell command, scan token and the counter refill formula.
// ----------------------------------------------------------------------------
package pcts_pkg;

  localparam int unsigned CNT_W       = 8;
  localparam int unsigned PRIO_W      = 10;
  localparam int unsigned QUOT_W      = 7;
  localparam int unsigned PROD_W      = 18;
  localparam int unsigned DIV10_MUL   = 205;
  localparam int unsigned DIV10_SHIFT = 11;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic              set_en;
    logic              dec_en;
    logic              refill_en;
    logic [PRIO_W-1:0] prio;
    logic              runnable;
  } cell_cmd_t;

  // best candidate handed from cell to cell
  typedef struct packed {
    logic             found;
    logic [CNT_W-1:0] counter;
  } token_t;

  // exact floor(p / 10) for any 10-bit p
  function automatic logic [QUOT_W-1:0] div10(input logic [PRIO_W-1:0] p);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(p) * PROD_W'(DIV10_MUL);
    return prod[DIV10_SHIFT +: QUOT_W];
  endfunction

  // counter / 2 + priority / 10, saturating
  function automatic logic [CNT_W-1:0] refill_value(input logic [CNT_W-1:0]  cnt,
                                                    input logic [PRIO_W-1:0] prio);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(cnt >> 1) + (CNT_W+1)'(div10(prio));
    return (sum > (CNT_W+1)'(CNT_MAX)) ? CNT_MAX : sum[CNT_W-1:0];
  endfunction

endpackage

// File: design/pcts_cell.sv
// ----------------------------------------------------------------------------
// pcts_cell
// One task slot: holds counter, priority and runnable flag, applies set,
// decrement and refill commands, and passes the scan token to its neighbor.
// ----------------------------------------------------------------------------
module pcts_cell #(
  parameter int unsigned IDX_W = 4
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [IDX_W-1:0]        slot,
  input  pcts_pkg::cell_cmd_t     cmd,
  input  logic [IDX_W-1:0]        cmd_index,
  input  pcts_pkg::token_t        tok_in,
  input  logic [IDX_W-1:0]        tok_in_index,
  output pcts_pkg::token_t        tok_out,
  output logic [IDX_W-1:0]        tok_out_index,
  output logic [pcts_pkg::CNT_W-1:0] counter
);
  import pcts_pkg::*;

  logic [CNT_W-1:0]  cnt;
  logic [PRIO_W-1:0] prio;
  logic              runnable;
  logic              hit;
  logic              take;

  assign hit     = (cmd_index == slot);
  assign take    = runnable && (!tok_in.found || (cnt > tok_in.counter));
  assign counter = cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      prio     <= '0;
      runnable <= 1'b1;
      tok_out  <= '0;
    end else begin
      if (cmd.set_en && hit) begin
        prio     <= cmd.prio;
        runnable <= cmd.runnable;
      end
      if (cmd.dec_en && hit && (cnt != '0)) begin
        cnt <= cnt - CNT_W'(1);
      end else if (cmd.refill_en) begin
        cnt <= refill_value(cnt, prio);
      end
      tok_out.found   <= tok_in.found | take;
      tok_out.counter <= take ? cnt : tok_in.counter;
    end
  end

  always_ff @(posedge clk) begin
    tok_out_index <= take ? slot : tok_in_index;
  end

endmodule

// File: design/priority_counter_task_scheduler_core.sv
// ----------------------------------------------------------------------------
// priority_counter_task_scheduler_core
// Time-slice scheduler over a chain of task cells: tick decrements the
// current task and reschedules by a systolic max scan, with counter refill.
//
//   channel  handshake              payload
//   input    in_valid / in_ready    req_type, task_index, new_priority,
//                                   new_runnable
//   output   out_valid / out_ready  selected_task, switched, recomputed,
//                                   stuck, selected_counter
//
// set transaction or tick without reschedule: IDLE, then DONE
// tick with scan: IDLE, SCAN1, DONE; with refill also REFILL and SCAN2
// the scan token walks one cell per cycle, which sets the scan length
// reset: synchronous, all slots runnable, counters zero
// in_ready is high whenever the sequencer is idle, even with a result pending
// ----------------------------------------------------------------------------
module priority_counter_task_scheduler_core #(
  parameter int unsigned TASK_COUNT = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       req_type,
  input  logic [3:0] task_index,
  input  logic [9:0] new_priority,
  input  logic       new_runnable,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] selected_task,
  output logic       switched,
  output logic       recomputed,
  output logic       stuck,
  output logic [7:0] selected_counter
);
  import pcts_pkg::*;

  localparam int unsigned IDX_W = $clog2(TASK_COUNT);
  localparam logic [IDX_W-1:0] SCAN_LAST = IDX_W'(TASK_COUNT - 1);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN1  = 5'b00010,
    ST_REFILL = 5'b00100,
    ST_SCAN2  = 5'b01000,
    ST_DONE   = 5'b10000
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [IDX_W-1:0]  cur;
  logic [IDX_W-1:0]  prev;
  logic [IDX_W-1:0]  scan_cnt;
  logic              rflag;
  logic              sflag;

  logic              in_accept;
  logic              out_free;
  logic              scan_done;
  logic              do_sched;
  logic              in_range;
  logic [IDX_W+3:0]  ext_index;
  logic [IDX_W+3:0]  ext_cur;
  logic [IDX_W-1:0]  set_index;
  logic [CNT_W-1:0]  cur_cnt;

  cell_cmd_t         cmd;
  logic [IDX_W-1:0]  cmd_index;

  token_t            tok       [1:TASK_COUNT];
  logic [IDX_W-1:0]  tok_index [1:TASK_COUNT];
  logic [CNT_W-1:0]  cnt_arr   [TASK_COUNT];

  assign in_ready  = (state == ST_IDLE);
  assign in_accept = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign scan_done = (scan_cnt == SCAN_LAST);

  assign ext_index = {IDX_W'(0), task_index};
  assign in_range  = (ext_index < (IDX_W+4)'(TASK_COUNT));
  assign set_index = ext_index[IDX_W-1:0];
  assign ext_cur   = {4'b0000, cur};

  assign cur_cnt  = cnt_arr[cur];
  assign do_sched = (cur == '0) || (cur_cnt <= CNT_W'(1));

  // command broadcast to the cell row
  always_comb begin
    cmd.set_en    = in_accept && req_type && in_range;
    cmd.dec_en    = in_accept && !req_type && (cur != '0);
    cmd.refill_en = (state == ST_REFILL);
    cmd.prio      = new_priority;
    cmd.runnable  = new_runnable;
    cmd_index     = req_type ? set_index : cur;
  end

  // idle slot holds no cell, its counter reads zero
  assign cnt_arr[0]             = '0;
  assign tok[TASK_COUNT]        = '0;
  assign tok_index[TASK_COUNT]  = '0;

  for (genvar i = 1; i < TASK_COUNT; i++) begin : g_cell
    pcts_cell #(
      .IDX_W(IDX_W)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .slot         (IDX_W'(i)),
      .cmd          (cmd),
      .cmd_index    (cmd_index),
      .tok_in       (tok[i+1]),
      .tok_in_index (tok_index[i+1]),
      .tok_out      (tok[i]),
      .tok_out_index(tok_index[i]),
      .counter      (cnt_arr[i])
    );
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          state_next = (!req_type && do_sched) ? ST_SCAN1 : ST_DONE;
        end
      end
      ST_SCAN1: begin
        if (scan_done) begin
          state_next = (tok[1].found && (tok[1].counter == '0)) ? ST_REFILL : ST_DONE;
        end
      end
      ST_REFILL: state_next = ST_SCAN2;
      ST_SCAN2: begin
        if (scan_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cur       <= '0;
      prev      <= '0;
      scan_cnt  <= '0;
      rflag     <= 1'b0;
      sflag     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_SCAN1 || state == ST_SCAN2) begin
        scan_cnt <= scan_cnt + IDX_W'(1);
      end else begin
        scan_cnt <= '0;
      end
      if (in_accept) begin
        prev  <= cur;
        rflag <= 1'b0;
        sflag <= 1'b0;
      end
      if (state == ST_SCAN1 && scan_done) begin
        if (!tok[1].found) begin
          cur <= '0;
        end else if (tok[1].counter != '0) begin
          cur <= tok_index[1];
        end
      end
      if (state == ST_REFILL) begin
        rflag <= 1'b1;
      end
      if (state == ST_SCAN2 && scan_done) begin
        if (tok[1].found && (tok[1].counter != '0)) begin
          cur <= tok_index[1];
        end else begin
          sflag <= 1'b1;
        end
      end
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      selected_task    <= ext_cur[3:0];
      switched         <= (cur != prev);
      recomputed       <= rflag;
      stuck            <= sflag;
      selected_counter <= cur_cnt;
    end
  end

`ifndef ASSERT_OFF
  a_stuck_after_refill: assert property (@(posedge clk) disable iff (rst)
    out_valid && stuck |-> recomputed)
    else $error("stuck reported without a refill");

  a_stuck_keeps_task: assert property (@(posedge clk) disable iff (rst)
    out_valid && stuck |-> !switched)
    else $error("task changed on a stuck schedule");

  a_switch_has_slice: assert property (@(posedge clk) disable iff (rst)
    out_valid && switched && (selected_task != 4'd0) |-> (selected_counter != 8'd0))
    else $error("switched to a task with an empty slice");

  a_cells_quiet_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN1 || state == ST_SCAN2) |-> !in_ready && !cmd.refill_en)
    else $error("cell state may change during a scan");
`endif

endmodule

// File: dv/priority_counter_task_scheduler_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// priority_counter_task_scheduler_core_tb
// Self-checking bench for the counter/priority time-slice scheduler. Timer
// ticks and task writes are driven through the input handshake while an
// in-bench scheduler model predicts each result. Results are compared field by
// field under several idle/stall mixes, including a long output hold-off.
// ----------------------------------------------------------------------------
module priority_counter_task_scheduler_core_tb;

  import pcts_pkg::CNT_W;
  import pcts_pkg::PRIO_W;
  import pcts_pkg::CNT_MAX;

  localparam int NUM_SLOTS   = 16;
  localparam int CYCLE_LIMIT = 400000;

  typedef enum logic {REQ_TICK = 1'b0, REQ_SET = 1'b1} req_kind_t;

  typedef struct packed {
    req_kind_t         kind;
    logic [3:0]        idx;
    logic [PRIO_W-1:0] prio;
    logic              run;
  } sched_req_t;

  typedef struct packed {
    logic [3:0]       sel_task;
    logic             sw;
    logic             recomp;
    logic             stk;
    logic [CNT_W-1:0] cnt;
  } sched_resp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic req_type = 1'b0;
  logic [3:0] task_index = '0;
  logic [9:0] new_priority = '0;
  logic new_runnable = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [3:0] selected_task;
  logic switched;
  logic recomputed;
  logic stuck;
  logic [7:0] selected_counter;

  // scheduler model state
  logic [CNT_W-1:0]  slice_cnt [NUM_SLOTS];
  logic [PRIO_W-1:0] prio_tab  [NUM_SLOTS];
  logic              run_tab   [NUM_SLOTS];
  logic [3:0]        cur_task;

  sched_req_t  pending_q[$];
  sched_resp_t resp_q[$];
  sched_req_t  drive_item;
  sched_req_t  nxt_item;
  sched_resp_t want;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_off = 1'b0;
  int err_cnt = 0;
  int gen_cnt = 0;
  int cycle_cnt = 0;
  int n_tick = 0;
  int n_set = 0;
  int n_switch = 0;
  int n_refill = 0;
  int n_stuck = 0;
  int n_idle = 0;

  priority_counter_task_scheduler_core #(
    .TASK_COUNT(NUM_SLOTS)
  ) u_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .req_type        (req_type),
    .task_index      (task_index),
    .new_priority    (new_priority),
    .new_runnable    (new_runnable),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .selected_task   (selected_task),
    .switched        (switched),
    .recomputed      (recomputed),
    .stuck           (stuck),
    .selected_counter(selected_counter)
  );

  always #5 clk = ~clk;

  // runnable slot with the largest counter, highest index on a tie
  function automatic int scan_best(output int best_cnt);
    int sel;
    sel = 0;
    best_cnt = -1;
    for (int i = NUM_SLOTS - 1; i >= 1; i--) begin
      if (run_tab[i] && int'(slice_cnt[i]) > best_cnt) begin
        best_cnt = int'(slice_cnt[i]);
        sel = i;
      end
    end
    return sel;
  endfunction

  function automatic sched_resp_t predict_schedule(input sched_req_t rq);
    sched_resp_t rs;
    logic [3:0] prev;
    int best;
    int sel;
    int unsigned v;
    logic run_scan;
    rs = '0;
    prev = cur_task;
    if (rq.kind == REQ_SET) begin
      prio_tab[rq.idx] = rq.prio;
      run_tab[rq.idx] = rq.run;
    end else begin
      run_scan = 1'b1;
      if (cur_task != 4'd0) begin
        if (slice_cnt[cur_task] != '0) slice_cnt[cur_task] = slice_cnt[cur_task] - CNT_W'(1);
        if (slice_cnt[cur_task] != '0) run_scan = 1'b0;
      end
      if (run_scan) begin
        sel = scan_best(best);
        if (best == 0) begin
          for (int i = 1; i < NUM_SLOTS; i++) begin
            v = int'(slice_cnt[i]) / 2 + int'(prio_tab[i]) / 10;
            slice_cnt[i] = (v > int'(CNT_MAX)) ? CNT_MAX : v[CNT_W-1:0];
          end
          rs.recomp = 1'b1;
          sel = scan_best(best);
          if (best == 0) begin
            rs.stk = 1'b1;
            sel = int'(cur_task);
          end
        end
        cur_task = sel[3:0];
      end
    end
    rs.sel_task = cur_task;
    rs.sw = (cur_task != prev);
    rs.cnt = slice_cnt[cur_task];
    return rs;
  endfunction

  function automatic void cmp_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t mismatch %s: expected %0d actual %0d", $time, name, exp_v, act_v);
      err_cnt++;
    end
  endfunction

  function automatic void add_set(int idx, int prio, bit run);
    sched_req_t r;
    r.kind = REQ_SET;
    r.idx = idx[3:0];
    r.prio = prio[PRIO_W-1:0];
    r.run = run;
    pending_q.push_back(r);
    gen_cnt++;
  endfunction

  function automatic void add_tick();
    sched_req_t r;
    r.kind = REQ_TICK;
    r.idx = 4'($urandom_range(0, 15));
    r.prio = PRIO_W'($urandom_range(0, 1023));
    r.run = 1'($urandom_range(0, 1));
    pending_q.push_back(r);
    gen_cnt++;
  endfunction

  // mostly small priorities so slices run out and rescheduling stays frequent
  function automatic int pick_prio();
    int r;
    r = $urandom_range(99);
    if (r < 65) return $urandom_range(0, 40);
    if (r < 85) return $urandom_range(0, 1023);
    if (r < 93) return 1023;
    return 0;
  endfunction

  function automatic void gen_traffic(int n);
    int start;
    int k;
    start = gen_cnt;
    while (gen_cnt - start < n) begin
      k = $urandom_range(99);
      if (k < 55) begin
        repeat ($urandom_range(1, 3))
          add_set($urandom_range(0, 15), pick_prio(), $urandom_range(99) < 75);
        repeat ($urandom_range(2, 8)) add_tick();
      end else if (k < 70) begin
        repeat ($urandom_range(5, 20)) add_tick();
      end else if (k < 78) begin
        // nothing runnable, falls back to idle
        for (int i = 1; i < NUM_SLOTS; i++) add_set(i, pick_prio(), 1'b0);
        repeat ($urandom_range(2, 4)) add_tick();
        repeat ($urandom_range(1, 4)) add_set($urandom_range(1, 15), pick_prio(), 1'b1);
        repeat ($urandom_range(2, 6)) add_tick();
      end else if (k < 86) begin
        // zero priorities, counters decay until refill cannot help
        for (int i = 1; i < NUM_SLOTS; i++) add_set(i, 0, $urandom_range(99) < 80);
        repeat ($urandom_range(10, 40)) add_tick();
      end else begin
        repeat ($urandom_range(1, 3))
          add_set($urandom_range(0, 15), $urandom_range(0, 1023), $urandom_range(0, 1) == 1);
      end
    end
  endfunction

  task automatic drain();
    while (pending_q.size() != 0 || in_valid || resp_q.size() != 0) @(negedge clk);
  endtask

  task automatic run_phase(int n, int s_idle, int r_stall);
    send_idle_pct = s_idle;
    recv_stall_pct = r_stall;
    gen_traffic(n);
    drain();
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        resp_q.push_back(predict_schedule(drive_item));
        if (drive_item.kind == REQ_TICK) n_tick++;
        else n_set++;
      end
      if (!in_valid || in_ready) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt_item = pending_q.pop_front();
          drive_item = nxt_item;
          in_valid <= 1'b1;
          req_type <= nxt_item.kind;
          task_index <= nxt_item.idx;
          new_priority <= nxt_item.prio;
          new_runnable <= nxt_item.run;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (resp_q.size() == 0) begin
          $display("%0t unexpected transaction: task %0d counter %0d", $time,
                   selected_task, selected_counter);
          err_cnt++;
        end else begin
          want = resp_q.pop_front();
          cmp_field("selected_task", 32'(want.sel_task), 32'(selected_task));
          cmp_field("switched", 32'(want.sw), 32'(switched));
          cmp_field("recomputed", 32'(want.recomp), 32'(recomputed));
          cmp_field("stuck", 32'(want.stk), 32'(stuck));
          cmp_field("selected_counter", 32'(want.cnt), 32'(selected_counter));
          if (switched) n_switch++;
          if (recomputed) n_refill++;
          if (stuck) n_stuck++;
          if (switched && selected_task == 4'd0) n_idle++;
        end
      end
      out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d transactions outstanding", cycle_cnt,
               resp_q.size());
      $display("FAIL priority_counter_task_scheduler_core");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slice_cnt[i] = '0;
      prio_tab[i] = '0;
      run_tab[i] = 1'b1;
    end
    cur_task = 4'd0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed sequence
    add_tick();
    add_set(0, 1023, 1'b0);
    add_set(15, 10, 1'b1);
    add_set(3, 1023, 1'b0);
    add_set(7, 20, 1'b1);
    add_set(8, 20, 1'b1);
    add_tick();
    add_tick();
    add_set(8, 20, 1'b0);
    add_tick();
    add_tick();
    add_tick();
    add_tick();
    add_set(3, 1023, 1'b1);
    add_tick();
    add_tick();
    add_set(3, 0, 1'b1);
    add_tick();
    add_set(15, 512, 1'b0);
    add_tick();
    drain();

    // output held off while the input keeps offering
    hold_off = 1'b1;
    gen_traffic(40);
    repeat (300) @(negedge clk);
    hold_off = 1'b0;
    drain();

    run_phase(85, 0, 0);
    run_phase(85, 85, 0);
    run_phase(85, 0, 85);
    run_phase(85, 14, 14);

    repeat (2 * NUM_SLOTS + 8) @(negedge clk);
    $display("covered %0d ticks and %0d task writes over five idle/stall mixes", n_tick, n_set);
    $display("seen %0d switches (%0d to idle), %0d refills, %0d stuck; %0d errors",
             n_switch, n_idle, n_refill, n_stuck, err_cnt);
    if (err_cnt == 0) begin
      $display("PASS priority_counter_task_scheduler_core");
    end else begin
      $display("FAIL priority_counter_task_scheduler_core");
    end
    $finish;
  end

endmodule

// File: sim.f
design/pcts_pkg.sv
design/pcts_cell.sv
design/priority_counter_task_scheduler_core.sv
dv/priority_counter_task_scheduler_core_tb.sv
